@@ src/aip_pkg.sv @@
// ----------------------------------------------------------------------------
// ASCII integer parser package
// Shared types and constants: character codes, base modes, sign codes and
// the character class that travels from the front end to the parse engine.
// ----------------------------------------------------------------------------
package aip_pkg;

    localparam int CH_W       = 8;
    localparam int OUT_VAL_W  = 32;
    localparam int OUT_OFS_W  = 8;
    localparam int MODE_W     = 2;

    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HEX  = 2'd2;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;

    localparam logic [1:0] HEX_NONE   = 2'd0;
    localparam logic [1:0] HEX_ZERO   = 2'd1;
    localparam logic [1:0] HEX_PREFIX = 2'd2;
    localparam logic [1:0] HEX_DIGIT  = 2'd3;

    localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CH_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CH_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CH_W-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CH_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CH_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [3:0]      HEX_TEN    = 4'hA;

    typedef struct packed {
        logic       nul;
        logic       ws;
        logic       plus;
        logic       minus;
        logic       x;
        logic       zero;
        logic       dec;
        logic       hex;
        logic [3:0] digit;
    } aip_class_t;

endpackage

@@ src/aip_if.sv @@
// ----------------------------------------------------------------------------
// ASCII integer parser channels
// Valid/ready channels for the character stream and the parse results.
// ----------------------------------------------------------------------------
interface aip_in_if;
    import aip_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

interface aip_out_if;
    import aip_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [OUT_VAL_W-1:0] value;
    logic [OUT_OFS_W-1:0]        stop_offset;

    modport source (output valid, output value, output stop_offset, input ready);
    modport sink   (input valid, input value, input stop_offset, output ready);
endinterface

@@ src/aip_front.sv @@
// ----------------------------------------------------------------------------
// ASCII integer parser front end
// Accepts characters and classifies each one for the parse engine.
// ----------------------------------------------------------------------------
module aip_front (
    aip_in_if.sink               chars,
    input  logic                 q_full,
    output logic                 q_push,
    output aip_pkg::aip_class_t  q_data
);
    import aip_pkg::*;

    logic [CH_W-1:0] c;

    assign c            = chars.ch;
    assign chars.ready  = !q_full;
    assign q_push       = chars.valid && !q_full;

    always_comb
    begin
        q_data       = '0;
        q_data.nul   = (c == CH_NUL);
        q_data.ws    = (c inside {[CH_TAB:CH_CR], CH_SPACE});
        q_data.plus  = (c == CH_PLUS);
        q_data.minus = (c == CH_MINUS);
        q_data.x     = (c == CH_LOWER_X) || (c == CH_UPPER_X);
        q_data.zero  = (c == CH_ZERO);
        q_data.dec   = (c inside {[CH_ZERO:CH_NINE]});
        if (c inside {[CH_ZERO:CH_NINE]})
        begin
            q_data.hex   = 1'b1;
            q_data.digit = c[3:0];
        end
        else if (c inside {[CH_LOWER_A:CH_LOWER_F]})
        begin
            q_data.hex   = 1'b1;
            q_data.digit = 4'(c - CH_LOWER_A) + HEX_TEN;
        end
        else if (c inside {[CH_UPPER_A:CH_UPPER_F]})
        begin
            q_data.hex   = 1'b1;
            q_data.digit = 4'(c - CH_UPPER_A) + HEX_TEN;
        end
    end

endmodule

@@ src/aip_queue.sv @@
// ----------------------------------------------------------------------------
// ASCII integer parser queue
// Two-entry queue of classified characters between front end and engine.
// ----------------------------------------------------------------------------
module aip_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  aip_pkg::aip_class_t  push_data,
    output logic                 full,
    input  logic                 pop,
    output aip_pkg::aip_class_t  pop_data,
    output logic                 empty
);
    import aip_pkg::*;

    aip_class_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/aip_back.sv @@
// ----------------------------------------------------------------------------
// ASCII integer parser engine
// Runs the decimal and hex parsers side by side and registers the result.
// ----------------------------------------------------------------------------
module aip_back #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_OFFSET  = 255,
    parameter int POS_W       = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [aip_pkg::MODE_W-1:0]   base_mode,
    input  logic                         q_empty,
    input  aip_pkg::aip_class_t          q_data,
    output logic                         q_pop,
    aip_out_if.source                    results
);
    import aip_pkg::*;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_OFFSET);

    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   dec_phase_reg, dec_phase_next;
    logic [1:0]             dec_sign_reg, dec_sign_next;
    logic [VALUE_WIDTH-1:0] dec_accum_reg, dec_accum_next;
    logic                   dec_done_reg, dec_done_next;
    logic [POS_W-1:0]       dec_stop_reg, dec_stop_next;
    logic [1:0]             hex_phase_reg, hex_phase_next;
    logic [1:0]             hex_sign_reg, hex_sign_next;
    logic [VALUE_WIDTH-1:0] hex_accum_reg, hex_accum_next;
    logic                   hex_done_reg, hex_done_next;
    logic [POS_W-1:0]       hex_stop_reg, hex_stop_next;

    logic                   out_valid_reg, out_valid_next;
    logic [OUT_VAL_W-1:0]   value_reg;
    logic [OUT_OFS_W-1:0]   stop_reg;

    logic                   take_ok;
    logic                   fin;
    logic                   dec_lead, hex_lead;
    logic [VALUE_WIDTH-1:0] dec_val, hex_val, val_sel;
    logic [POS_W-1:0]       dec_ofs, hex_ofs, ofs_sel;
    logic [OUT_VAL_W-1:0]   value_ext;
    logic [OUT_OFS_W-1:0]   stop_ext;

    assign take_ok = !q_data.nul || !out_valid_reg || results.ready;
    assign q_pop   = !q_empty && take_ok;
    assign fin     = q_pop && q_data.nul;

    assign dec_lead = !dec_phase_reg && (dec_sign_reg == SIGN_NONE);
    assign hex_lead = (hex_phase_reg == HEX_NONE) && (hex_sign_reg == SIGN_NONE);

    always_comb
    begin
        pos_next       = pos_reg;
        dec_phase_next = dec_phase_reg;
        dec_sign_next  = dec_sign_reg;
        dec_accum_next = dec_accum_reg;
        dec_done_next  = dec_done_reg;
        dec_stop_next  = dec_stop_reg;
        hex_phase_next = hex_phase_reg;
        hex_sign_next  = hex_sign_reg;
        hex_accum_next = hex_accum_reg;
        hex_done_next  = hex_done_reg;
        hex_stop_next  = hex_stop_reg;
        if (fin)
        begin
            pos_next       = '0;
            dec_phase_next = 1'b0;
            dec_sign_next  = SIGN_NONE;
            dec_accum_next = '0;
            dec_done_next  = 1'b0;
            dec_stop_next  = '0;
            hex_phase_next = HEX_NONE;
            hex_sign_next  = SIGN_NONE;
            hex_accum_next = '0;
            hex_done_next  = 1'b0;
            hex_stop_next  = '0;
        end
        else if (q_pop)
        begin
            if (!dec_done_reg && !(dec_lead && q_data.ws))
            begin
                if (q_data.dec)
                begin
                    dec_phase_next = 1'b1;
                    dec_accum_next = (dec_accum_reg << 3) + (dec_accum_reg << 1)
                                   + VALUE_WIDTH'(q_data.digit);
                end
                else if (dec_lead && q_data.plus)
                begin
                    dec_sign_next = SIGN_PLUS;
                end
                else if (dec_lead && q_data.minus)
                begin
                    dec_sign_next = SIGN_MINUS;
                end
                else
                begin
                    dec_done_next = 1'b1;
                    dec_stop_next = pos_reg;
                end
            end
            if (!hex_done_reg && !(hex_lead && q_data.ws))
            begin
                if (q_data.hex)
                begin
                    if ((hex_phase_reg == HEX_NONE) && q_data.zero)
                    begin
                        hex_phase_next = HEX_ZERO;
                    end
                    else
                    begin
                        hex_phase_next = HEX_DIGIT;
                        hex_accum_next = (hex_accum_reg << 4)
                                       + VALUE_WIDTH'(q_data.digit);
                    end
                end
                else if (hex_lead && q_data.plus)
                begin
                    hex_sign_next = SIGN_PLUS;
                end
                else if (hex_lead && q_data.minus)
                begin
                    hex_sign_next = SIGN_MINUS;
                end
                else if ((hex_phase_reg == HEX_ZERO) && q_data.x)
                begin
                    hex_phase_next = HEX_PREFIX;
                end
                else
                begin
                    hex_done_next = 1'b1;
                    hex_stop_next = pos_reg;
                end
            end
            if (pos_reg < MAX_POS)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        dec_val = (dec_sign_reg == SIGN_MINUS) ? (VALUE_WIDTH'(0) - dec_accum_reg)
                                               : dec_accum_reg;
        hex_val = (hex_sign_reg == SIGN_MINUS) ? (VALUE_WIDTH'(0) - hex_accum_reg)
                                               : hex_accum_reg;
        dec_ofs = dec_done_reg ? dec_stop_reg : pos_reg;
        if ((dec_sign_reg != SIGN_NONE) && !dec_phase_reg)
        begin
            dec_ofs = '0;
        end
        hex_ofs = hex_done_reg ? hex_stop_reg : pos_reg;
        if ((hex_phase_reg == HEX_PREFIX)
            || ((hex_sign_reg != SIGN_NONE) && (hex_phase_reg == HEX_NONE)))
        begin
            hex_ofs = '0;
        end
        case (base_mode)
            MODE_DEC:
            begin
                val_sel = dec_val;
                ofs_sel = dec_ofs;
            end
            MODE_HEX:
            begin
                val_sel = hex_val;
                ofs_sel = hex_ofs;
            end
            MODE_AUTO:
            begin
                val_sel = (dec_val != '0) ? dec_val : hex_val;
                ofs_sel = (dec_val != '0) ? dec_ofs : hex_ofs;
            end
            default:
            begin
                val_sel = '0;
                ofs_sel = '0;
            end
        endcase
    end

    generate
        if (VALUE_WIDTH >= OUT_VAL_W)
        begin : g_val_trunc
            assign value_ext = val_sel[OUT_VAL_W-1:0];
        end
        else
        begin : g_val_sext
            assign value_ext = {{(OUT_VAL_W-VALUE_WIDTH){val_sel[VALUE_WIDTH-1]}}, val_sel};
        end
        if (POS_W >= OUT_OFS_W)
        begin : g_ofs_trunc
            assign stop_ext = ofs_sel[OUT_OFS_W-1:0];
        end
        else
        begin : g_ofs_zext
            assign stop_ext = {{(OUT_OFS_W-POS_W){1'b0}}, ofs_sel};
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            dec_phase_reg <= 1'b0;
            dec_sign_reg  <= SIGN_NONE;
            dec_accum_reg <= '0;
            dec_done_reg  <= 1'b0;
            dec_stop_reg  <= '0;
            hex_phase_reg <= HEX_NONE;
            hex_sign_reg  <= SIGN_NONE;
            hex_accum_reg <= '0;
            hex_done_reg  <= 1'b0;
            hex_stop_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            dec_phase_reg <= dec_phase_next;
            dec_sign_reg  <= dec_sign_next;
            dec_accum_reg <= dec_accum_next;
            dec_done_reg  <= dec_done_next;
            dec_stop_reg  <= dec_stop_next;
            hex_phase_reg <= hex_phase_next;
            hex_sign_reg  <= hex_sign_next;
            hex_accum_reg <= hex_accum_next;
            hex_done_reg  <= hex_done_next;
            hex_stop_reg  <= hex_stop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            value_reg <= value_ext;
            stop_reg  <= stop_ext;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.value       = value_reg;
    assign results.stop_offset = stop_reg;

    a_clear_after_nul: assert property (@(posedge clk) disable iff (!rst_n)
        fin |=> (pos_reg == '0) && !dec_done_reg && !hex_done_reg)
        else $error("parse state not cleared after string end");

    a_dec_stop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dec_done_reg |-> (dec_stop_reg <= pos_reg))
        else $error("decimal stop beyond position");

    a_hex_stop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hex_done_reg |-> (hex_stop_reg <= pos_reg))
        else $error("hex stop beyond position");

    a_prefix_accum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (hex_phase_reg == HEX_PREFIX) |-> (hex_accum_reg == '0))
        else $error("hex accumulator set before first digit");

    a_result_from_nul: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(fin))
        else $error("result raised without string end");

endmodule

@@ src/ascii_integer_parser.sv @@
// ----------------------------------------------------------------------------
// ASCII integer parser
// Converts a NUL-terminated character stream into a signed integer and the
// offset of the first character not consumed, in decimal, hex or auto base.
//
// Channel chars carries one character per transfer; the value 0 ends a
// string. Channel results carries one value/stop_offset pair per string,
// and nothing for the other characters. base_mode is written through
// cfg_we/cfg_wdata (0 auto, 1 decimal, 2 hex); the user writes it only while
// no string is in flight, the block does not enforce this. Throughput: one
// character per cycle while chars.ready is high. Each character is classified
// on transfer, waits in a two-entry queue, then updates the decimal and hex
// parse state (multiply by ten and shift by four are shift-add paths). The
// result is valid in the cycle after the clock edge that moves the
// terminating NUL out of the queue, into which it was written on its
// transfer. While results is stalled, characters keep flowing into the
// engine; a second NUL waits in the queue until the held result is taken,
// and the queue then fills and deasserts chars.ready. Reset empties the
// queue, clears the parse state and sets base_mode to decimal.
// ----------------------------------------------------------------------------
module ascii_integer_parser #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_OFFSET  = 255
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [aip_pkg::MODE_W-1:0] cfg_wdata,
    aip_in_if.sink                     chars,
    aip_out_if.source                  results
);
    import aip_pkg::*;

    localparam int POS_W = $clog2(MAX_OFFSET + 1);

    logic [MODE_W-1:0] base_mode_reg, base_mode_next;
    logic              q_push, q_full, q_pop, q_empty;
    aip_class_t        q_in, q_out;

    always_comb
    begin
        base_mode_next = cfg_we ? cfg_wdata : base_mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg <= MODE_DEC;
        end
        else
        begin
            base_mode_reg <= base_mode_next;
        end
    end

    aip_front u_front (
        .chars  (chars),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    aip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    aip_back #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_OFFSET  (MAX_OFFSET),
        .POS_W       (POS_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .base_mode (base_mode_reg),
        .q_empty   (q_empty),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .results   (results)
    );

endmodule
